// ===== rtl/ufd_pkg.sv =====
// shared types and constants for the ultrasonic frame deframer
`default_nettype none

package ufd_pkg;

    localparam int COUNT_W        = 5;
    localparam int DEF_BUFFER_BYTES = 20;
    localparam int FRAME_BYTES    = 15;
    localparam int NUM_DIST       = 6;
    localparam int DIST_W         = 16;

    localparam logic [7:0] HEAD_FIRST  = 8'hA5;
    localparam logic [7:0] HEAD_SECOND = 8'h5A;

    // first data byte of the distance field
    localparam int DIST_FIRST_BYTE = 2;

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_IDLE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_LENGTH   = 2'd1,
        STATUS_BAD_HEADER   = 2'd2,
        STATUS_BAD_CHECKSUM = 2'd3
    } frame_status_t;

    typedef logic [NUM_DIST-1:0][DIST_W-1:0] dist_set_t;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_frame_deframer.sv =====
// top level: byte counting, header and checksum check, distance hold and result register
`default_nettype none

// Takes one word per cycle: a data byte (cmd 0) or a line-idle mark (cmd 1) that
// closes the frame. Each word is first captured in an input register; a data word
// is then folded into the running count, sums, header flag and staged distances,
// and an idle word, once the result register is free, loads it with status and length
// and updates the held distances on a good frame. A data word yields no result;
// an idle word passes the input and result registers on its way to the m_ side.
// The sustained rate is one word per cycle; it drops only while a finished result
// waits in the result register and another idle word is behind it. Frames longer
// than BUFFER_BYTES keep counting at BUFFER_BYTES and drop the extra bytes.
module ultrasonic_frame_deframer
    import ufd_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [7:0]           s_rx_byte,

    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic [1:0]           m_frame_status,
    output      logic [COUNT_W-1:0]   m_frame_length,
    output      logic [DIST_W-1:0]    m_front_left_distance,
    output      logic [DIST_W-1:0]    m_front_right_distance,
    output      logic [DIST_W-1:0]    m_side_left_distance,
    output      logic [DIST_W-1:0]    m_side_right_distance,
    output      logic [DIST_W-1:0]    m_rear_left_distance,
    output      logic [DIST_W-1:0]    m_rear_right_distance
);

    localparam logic [COUNT_W-1:0] BUF_LIMIT   = COUNT_W'(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(FRAME_BYTES);

    // input register
    logic             in_valid_reg;
    cmd_t             in_cmd_reg;
    logic [7:0]       in_byte_reg;

    // frame state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         sum_before_last_reg, sum_before_last_next;
    logic [7:0]         sum_all_reg, sum_all_next;
    logic [7:0]         last_byte_reg, last_byte_next;
    logic               header_good_reg, header_good_next;
    dist_set_t          staged_reg, staged_next;
    dist_set_t          held_reg, held_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    frame_status_t      out_status_reg, status_next;
    logic [COUNT_W-1:0] out_length_reg;

    logic out_free;
    logic consume;
    logic data_fire;
    logic idle_fire;
    logic frame_ok;

    assign out_free  = !out_valid_reg || m_ready;
    assign consume   = in_valid_reg && ((in_cmd_reg == CMD_DATA) || out_free);
    assign data_fire = consume && (in_cmd_reg == CMD_DATA);
    assign idle_fire = consume && (in_cmd_reg == CMD_IDLE);
    assign s_ready   = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= cmd_t'(s_cmd);
            in_byte_reg <= s_rx_byte;
        end
    end

    // checks in order: length, header, checksum
    always_comb begin
        priority if (byte_count_reg != FRAME_LIMIT) begin
            status_next = STATUS_BAD_LENGTH;
        end else if (!header_good_reg) begin
            status_next = STATUS_BAD_HEADER;
        end else if (sum_before_last_reg != last_byte_reg) begin
            status_next = STATUS_BAD_CHECKSUM;
        end else begin
            status_next = STATUS_OK;
        end
    end

    assign frame_ok = (status_next == STATUS_OK);

    always_comb begin
        byte_count_next      = byte_count_reg;
        sum_before_last_next = sum_before_last_reg;
        sum_all_next         = sum_all_reg;
        last_byte_next       = last_byte_reg;
        header_good_next     = header_good_reg;
        staged_next          = staged_reg;
        held_next            = held_reg;

        if (idle_fire) begin
            if (frame_ok) begin
                held_next = staged_reg;
            end
            byte_count_next      = '0;
            sum_before_last_next = '0;
            sum_all_next         = '0;
            last_byte_next       = '0;
            header_good_next     = 1'b0;
        end else if (data_fire && (byte_count_reg < BUF_LIMIT)) begin
            if (byte_count_reg == COUNT_W'(0)) begin
                header_good_next = (in_byte_reg == HEAD_FIRST);
            end else if (byte_count_reg == COUNT_W'(1)) begin
                header_good_next = header_good_reg && (in_byte_reg == HEAD_SECOND);
            end
            // big-endian: even byte position is the high half
            for (int i = 0; i < NUM_DIST; i++) begin
                if (byte_count_reg == COUNT_W'(DIST_FIRST_BYTE + 2*i)) begin
                    staged_next[i][15:8] = in_byte_reg;
                end
                if (byte_count_reg == COUNT_W'(DIST_FIRST_BYTE + 2*i + 1)) begin
                    staged_next[i][7:0] = in_byte_reg;
                end
            end
            sum_before_last_next = sum_all_reg;
            sum_all_next         = sum_all_reg + in_byte_reg;
            last_byte_next       = in_byte_reg;
            byte_count_next      = byte_count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= '0;
            sum_before_last_reg <= '0;
            sum_all_reg         <= '0;
            last_byte_reg       <= '0;
            header_good_reg     <= 1'b0;
            staged_reg          <= '0;
            held_reg            <= '0;
        end else begin
            byte_count_reg      <= byte_count_next;
            sum_before_last_reg <= sum_before_last_next;
            sum_all_reg         <= sum_all_next;
            last_byte_reg       <= last_byte_next;
            header_good_reg     <= header_good_next;
            staged_reg          <= staged_next;
            held_reg            <= held_next;
        end
    end

    always_comb begin
        if (idle_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // held distances come straight from held_reg, which only moves on an idle
    always_ff @(posedge aclk) begin
        if (idle_fire) begin
            out_status_reg <= status_next;
            out_length_reg <= byte_count_reg;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_frame_status         = out_status_reg;
    assign m_frame_length         = out_length_reg;
    assign m_front_left_distance  = held_reg[0];
    assign m_front_right_distance = held_reg[1];
    assign m_side_left_distance   = held_reg[2];
    assign m_side_right_distance  = held_reg[3];
    assign m_rear_left_distance   = held_reg[4];
    assign m_rear_right_distance  = held_reg[5];

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= BUF_LIMIT)
        else $error("byte count above buffer size");

    a_idle_clears_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_fire |=> (byte_count_reg == '0) && !header_good_reg && (sum_all_reg == '0))
        else $error("frame state not cleared after idle");

    a_ok_has_frame_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg == STATUS_OK)) |-> (out_length_reg == FRAME_LIMIT))
        else $error("ok status with wrong frame length");

    a_held_only_on_good_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !(idle_fire && frame_ok) |=> $stable(held_reg))
        else $error("held distances changed without a good frame");

    a_result_stalls_on_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg && (in_cmd_reg == CMD_IDLE)) |-> !s_ready)
        else $error("idle word taken while result is stalled");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the ultrasonic frame deframer
`timescale 1ns / 100ps

module testbench;
    import ufd_pkg::*;

    localparam int BUF_BYTES      = DEF_BUFFER_BYTES;
    localparam int LAST_DIST_BYTE = DIST_FIRST_BYTE + 2 * NUM_DIST - 1;
    localparam int SUM_BYTE       = FRAME_BYTES - 1;
    localparam int RANDOM_WORDS   = 750;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } rx_word_t;

    typedef struct packed {
        frame_status_t        status;
        logic [COUNT_W-1:0]   length;
        dist_set_t            distances;
    } frame_report_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_HEAD,
        FR_SHORT,
        FR_LONG,
        FR_NOISE
    } frame_kind_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_cmd     = CMD_DATA;
    logic [7:0]          s_rx_byte = 8'h00;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [1:0]          m_frame_status;
    logic [COUNT_W-1:0]  m_frame_length;
    logic [DIST_W-1:0]   m_front_left_distance;
    logic [DIST_W-1:0]   m_front_right_distance;
    logic [DIST_W-1:0]   m_side_left_distance;
    logic [DIST_W-1:0]   m_side_right_distance;
    logic [DIST_W-1:0]   m_rear_left_distance;
    logic [DIST_W-1:0]   m_rear_right_distance;

    dist_set_t got_dist;
    assign got_dist = {m_rear_right_distance, m_rear_left_distance,
                       m_side_right_distance, m_side_left_distance,
                       m_front_right_distance, m_front_left_distance};

    string dist_label [NUM_DIST] = '{"front_left_distance", "front_right_distance",
                                     "side_left_distance", "side_right_distance",
                                     "rear_left_distance", "rear_right_distance"};

    rx_word_t      pending_words [$];
    frame_report_t pending_reports [$];
    logic [7:0]    frame_buf [$];
    frame_report_t oldest_report;
    rx_word_t      next_word;
    int            err_cnt = 0;

    // frame tracking state mirrored from the block
    int            byte_cnt  = 0;
    logic [7:0]    sum_prev  = 8'h00;
    logic [7:0]    sum_run   = 8'h00;
    logic [7:0]    last_b    = 8'h00;
    logic          head_ok   = 1'b0;
    dist_set_t     staged    = '0;
    dist_set_t     held      = '0;

    // driver / stall state
    logic taken_q    = 1'b0;
    int   send_gap   = 0;
    int   recv_stall = 0;
    bit   send_quiet = 1'b0;
    bit   recv_quiet = 1'b0;

    ultrasonic_frame_deframer i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_cmd                  (s_cmd),
        .s_rx_byte              (s_rx_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_frame_status         (m_frame_status),
        .m_frame_length         (m_frame_length),
        .m_front_left_distance  (m_front_left_distance),
        .m_front_right_distance (m_front_right_distance),
        .m_side_left_distance   (m_side_left_distance),
        .m_side_right_distance  (m_side_right_distance),
        .m_rear_left_distance   (m_rear_left_distance),
        .m_rear_right_distance  (m_rear_right_distance)
    );

    always #5 aclk = ~aclk;

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] head_sum();
        logic [7:0] s;
        s = 8'h00;
        for (int i = 0; i < SUM_BYTE; i++) s = s + frame_buf[i];
        return s;
    endfunction

    task automatic push_word(input cmd_t c, input logic [7:0] b);
        rx_word_t w;
        w.cmd  = c;
        w.data = b;
        pending_words.push_back(w);
    endtask

    task automatic close_frame();
        foreach (frame_buf[i]) push_word(CMD_DATA, frame_buf[i]);
        push_word(CMD_IDLE, 8'($urandom));
        frame_buf.delete();
    endtask

    task automatic build_good();
        frame_buf.delete();
        frame_buf.push_back(HEAD_FIRST);
        frame_buf.push_back(HEAD_SECOND);
        for (int i = DIST_FIRST_BYTE; i <= LAST_DIST_BYTE; i++) frame_buf.push_back(rand_byte());
        frame_buf.push_back(head_sum());
    endtask

    task automatic push_random_frame();
        int r;
        int n;
        frame_kind_t kind;
        r = $urandom_range(0, 99);
        if (r < 40)      kind = FR_GOOD;
        else if (r < 52) kind = FR_BAD_SUM;
        else if (r < 64) kind = FR_BAD_HEAD;
        else if (r < 78) kind = FR_SHORT;
        else if (r < 90) kind = FR_LONG;
        else             kind = FR_NOISE;
        build_good();
        case (kind)
            FR_BAD_SUM: begin
                frame_buf[SUM_BYTE] = frame_buf[SUM_BYTE] + 8'($urandom_range(1, 255));
            end
            FR_BAD_HEAD: begin
                n = $urandom_range(0, 2);
                if (n != 1) frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
                if (n != 0) frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
                // half of them keep a valid sum so only the header check trips
                if ($urandom_range(0, 1) == 1) frame_buf[SUM_BYTE] = head_sum();
            end
            FR_SHORT: begin
                n = $urandom_range(0, FRAME_BYTES - 1);
                while (frame_buf.size() > n) void'(frame_buf.pop_back());
            end
            FR_LONG: begin
                n = $urandom_range(1, BUF_BYTES + 10 - FRAME_BYTES);
                repeat (n) frame_buf.push_back(rand_byte());
            end
            FR_NOISE: begin
                frame_buf.delete();
                n = $urandom_range(0, 24);
                repeat (n) frame_buf.push_back(8'($urandom));
            end
            default: ;
        endcase
        close_frame();
    endtask

    task automatic predict_word(input cmd_t c, input logic [7:0] b);
        frame_report_t rep;
        int k;
        if (c == CMD_DATA) begin
            // bytes past the buffer end are dropped without a trace
            if (byte_cnt < BUF_BYTES) begin
                if (byte_cnt == 0)      head_ok = (b == HEAD_FIRST);
                else if (byte_cnt == 1) head_ok = head_ok && (b == HEAD_SECOND);
                if (byte_cnt >= DIST_FIRST_BYTE && byte_cnt <= LAST_DIST_BYTE) begin
                    k = (byte_cnt - DIST_FIRST_BYTE) / 2;
                    if (byte_cnt % 2 == 0) staged[k][15:8] = b;
                    else                   staged[k][7:0]  = b;
                end
                sum_prev = sum_run;
                sum_run  = sum_run + b;
                last_b   = b;
                byte_cnt++;
            end
        end else begin
            if (byte_cnt != FRAME_BYTES) rep.status = STATUS_BAD_LENGTH;
            else if (!head_ok)           rep.status = STATUS_BAD_HEADER;
            else if (sum_prev != last_b) rep.status = STATUS_BAD_CHECKSUM;
            else                         rep.status = STATUS_OK;
            if (rep.status == STATUS_OK) held = staged;
            rep.length    = COUNT_W'(byte_cnt);
            rep.distances = held;
            pending_reports.push_back(rep);
            byte_cnt = 0;
            sum_prev = 8'h00;
            sum_run  = 8'h00;
            last_b   = 8'h00;
            head_ok  = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // monitor: prediction on accepted words, checking on accepted reports
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_word(cmd_t'(s_cmd), s_rx_byte);
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("report accepted with none expected");
                    err_cnt++;
                end else begin
                    oldest_report = pending_reports.pop_front();
                    check_field("frame_status", oldest_report.status, m_frame_status);
                    check_field("frame_length", oldest_report.length, m_frame_length);
                    for (int i = 0; i < NUM_DIST; i++)
                        check_field(dist_label[i], oldest_report.distances[i], got_dist[i]);
                end
            end
        end
        taken_q <= aresetn && s_valid && s_ready;
    end

    // driver: one word at a time, with random gaps after each word
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !taken_q)) begin
            if ($urandom_range(0, 39) == 0) send_quiet <= !send_quiet;
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() > 0) begin
                next_word = pending_words.pop_front();
                s_valid   <= 1'b1;
                s_cmd     <= next_word.cmd;
                s_rx_byte <= next_word.data;
                send_gap  <= send_quiet ? 0 : next_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // report side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 39) == 0) recv_quiet <= !recv_quiet;
            if (recv_stall > 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if (!recv_quiet && $urandom_range(0, 3) == 0) recv_stall <= next_gap();
            end
        end
    end

    initial begin
        // empty frame right after reset
        push_word(CMD_IDLE, 8'hFF);
        // good frame with extreme distance values
        frame_buf = {HEAD_FIRST, HEAD_SECOND, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01,
                     8'h7F, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'hFF};
        frame_buf.push_back(head_sum());
        close_frame();
        // header only, then closed
        frame_buf = {HEAD_FIRST, HEAD_SECOND};
        close_frame();
        while (pending_words.size() < RANDOM_WORDS) push_random_frame();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ufd_pkg.sv
rtl/ultrasonic_frame_deframer.sv
tb/testbench.sv
